[hdl/rrb_pkg.sv]
// shared types and fixed field widths for the receive reorder buffer
package rrb_pkg;

  // fixed widths of the event fields
  localparam int SEQ_PORT_W = 7;
  localparam int TAG_W      = 7;
  localparam int LEN_W      = 16;

  // controller to datapath commands
  typedef struct packed {
    logic capture;    // take the input transfer into the item register
    logic hold_wr;    // write the item into its holding slot
    logic pass_load;  // load the item into the output register as is
    logic rd_en;      // read a holding slot
    logic rd_next;    // read the slot after the expected one
    logic emit_load;  // load the slot just read into the output register
  } rrb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic trunc;      // item was cut short
    logic ordered;    // item carries a sequence
    logic drop;       // outside the window or already held
    logic expected;   // item sequence equals the expected one
    logic run_end;    // slot after the expected one is empty
    logic out_free;   // output register can take a result this cycle
  } rrb_stat_t;

endpackage

[hdl/rrb_datapath.sv]
// item register, sequence tracking, holding store and output register
module rrb_datapath #(
  parameter int SEQ_BITS   = 7,
  parameter int DUP_WINDOW = 64,
  parameter int REF_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_first_in_packet,
  input  logic                            in_guaranteed,
  input  logic                            in_continuous,
  input  logic                            in_has_explicit,
  input  logic [rrb_pkg::SEQ_PORT_W-1:0]  in_explicit_seq,
  input  logic [rrb_pkg::TAG_W-1:0]       in_class_tag,
  input  logic [REF_BITS-1:0]             in_payload_ref,
  input  logic [rrb_pkg::LEN_W-1:0]       in_payload_len,
  input  logic                            in_truncated,
  input  rrb_pkg::rrb_cmd_t               cmd,
  output rrb_pkg::rrb_stat_t              stat,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [rrb_pkg::SEQ_PORT_W-1:0]  out_seq,
  output logic                            out_ordered,
  output logic                            out_guaranteed,
  output logic [rrb_pkg::TAG_W-1:0]       out_class_tag,
  output logic [REF_BITS-1:0]             out_payload_ref,
  output logic [rrb_pkg::LEN_W-1:0]       out_payload_len,
  output logic                            out_last
);

  localparam int DEPTH   = 1 << SEQ_BITS;
  localparam int ENTRY_W = rrb_pkg::TAG_W + REF_BITS + rrb_pkg::LEN_W;
  localparam int WIDE_W  = SEQ_BITS + rrb_pkg::SEQ_PORT_W;

  // sequence tracking
  logic [SEQ_BITS-1:0]  prev_seq_r;
  logic                 prev_valid_r;
  logic [SEQ_BITS-1:0]  ne_r;
  logic [SEQ_BITS-1:0]  ne_plus1;

  // item register
  logic [SEQ_BITS-1:0]        seq_r;
  logic                       ordered_r;
  logic                       trunc_r;
  logic                       guar_r;
  logic [rrb_pkg::TAG_W-1:0]  tag_r;
  logic [REF_BITS-1:0]        ref_r;
  logic [rrb_pkg::LEN_W-1:0]  len_r;

  // holding store
  logic [DEPTH-1:0]    valid_r;
  logic [ENTRY_W-1:0]  mem [DEPTH];
  logic [ENTRY_W-1:0]  rd_data_r;
  logic [SEQ_BITS-1:0] rd_addr;

  // output register
  logic                            out_valid_r;
  logic [rrb_pkg::SEQ_PORT_W-1:0]  out_seq_r;
  logic                            out_ordered_r;
  logic                            out_guar_r;
  logic [rrb_pkg::TAG_W-1:0]       out_tag_r;
  logic [REF_BITS-1:0]             out_ref_r;
  logic [rrb_pkg::LEN_W-1:0]       out_len_r;
  logic                            out_last_r;

  // resolved sequence of the incoming transfer
  logic [WIDE_W-1:0]    exp_wide;
  logic [SEQ_BITS-1:0]  exp_seq;
  logic                 pv_eff;
  logic                 ord_in;
  logic [SEQ_BITS-1:0]  seq_in;
  logic [SEQ_BITS-1:0]  ahead;
  logic [31:0]          ahead_ext;
  logic                 in_window;
  logic [WIDE_W-1:0]    ne_wide;

  assign exp_wide = {{SEQ_BITS{1'b0}}, in_explicit_seq};
  assign exp_seq  = exp_wide[SEQ_BITS-1:0];
  assign pv_eff   = prev_valid_r & ~in_first_in_packet;
  assign ne_plus1 = ne_r + SEQ_BITS'(1);
  assign ne_wide  = {{rrb_pkg::SEQ_PORT_W{1'b0}}, ne_r};

  always_comb begin
    ord_in = 1'b0;
    seq_in = '0;
    if (in_guaranteed) begin
      if (in_continuous) begin
        ord_in = 1'b1;
        seq_in = pv_eff ? prev_seq_r + SEQ_BITS'(1) : '0;
      end else if (in_has_explicit) begin
        ord_in = 1'b1;
        seq_in = exp_seq;
      end
    end
  end

  // previous sequence in the packet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_seq_r   <= '0;
      prev_valid_r <= 1'b0;
    end else if (cmd.capture) begin
      if (ord_in) begin
        prev_seq_r   <= seq_in;
        prev_valid_r <= 1'b1;
      end else if (in_first_in_packet) begin
        prev_valid_r <= 1'b0;
      end
    end
  end

  // item register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seq_r     <= seq_in;
      ordered_r <= ord_in;
      trunc_r   <= in_truncated;
      guar_r    <= in_guaranteed;
      tag_r     <= in_class_tag;
      ref_r     <= in_payload_ref;
      len_r     <= in_payload_len;
    end
  end

  // window and duplicate checks
  assign ahead     = seq_r - ne_r;
  assign ahead_ext = 32'(ahead);
  assign in_window = ahead_ext < 32'(DUP_WINDOW);

  assign stat.trunc    = trunc_r;
  assign stat.ordered  = ordered_r;
  assign stat.drop     = ~in_window | valid_r[seq_r];
  assign stat.expected = (seq_r == ne_r);
  assign stat.run_end  = ~valid_r[ne_plus1];
  assign stat.out_free = ~out_valid_r | ~out_stall;

  // slot valid bits and expected sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ne_r    <= '0;
    end else begin
      if (cmd.hold_wr) begin
        valid_r[seq_r] <= 1'b1;
      end
      if (cmd.emit_load) begin
        valid_r[ne_r] <= 1'b0;
        ne_r          <= ne_plus1;
      end
    end
  end

  // holding store, registered read
  assign rd_addr = cmd.rd_next ? ne_plus1 : ne_r;

  always_ff @(posedge clk) begin
    if (cmd.hold_wr) begin
      mem[seq_r] <= {tag_r, ref_r, len_r};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pass_load || cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_load) begin
      out_seq_r     <= '0;
      out_ordered_r <= 1'b0;
      out_guar_r    <= guar_r;
      out_tag_r     <= tag_r;
      out_ref_r     <= ref_r;
      out_len_r     <= len_r;
      out_last_r    <= 1'b1;
    end else if (cmd.emit_load) begin
      out_seq_r     <= ne_wide[rrb_pkg::SEQ_PORT_W-1:0];
      out_ordered_r <= 1'b1;
      out_guar_r    <= 1'b1;
      out_tag_r     <= rd_data_r[ENTRY_W-1 -: rrb_pkg::TAG_W];
      out_ref_r     <= rd_data_r[rrb_pkg::LEN_W +: REF_BITS];
      out_len_r     <= rd_data_r[rrb_pkg::LEN_W-1:0];
      out_last_r    <= stat.run_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_seq         = out_seq_r;
  assign out_ordered     = out_ordered_r;
  assign out_guaranteed  = out_guar_r;
  assign out_class_tag   = out_tag_r;
  assign out_payload_ref = out_ref_r;
  assign out_payload_len = out_len_r;
  assign out_last        = out_last_r;

  // a held slot is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hold_wr |-> !valid_r[seq_r])
    else $error("write into an occupied holding slot");

  // a drained slot must have been held
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> valid_r[ne_r])
    else $error("drain of an empty holding slot");

  // a run that continues leaves the next expected slot occupied
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && !stat.run_end) |=> valid_r[ne_r])
    else $error("drain run continued past an empty slot");

endmodule

[hdl/rrb_ctrl.sv]
// controller state machine for the receive reorder buffer
module rrb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rrb_pkg::rrb_stat_t  stat,
  output rrb_pkg::rrb_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.trunc) begin
          state_nxt = S_IDLE;
        end else if (!stat.ordered) begin
          if (stat.out_free) begin
            cmd.pass_load = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (stat.drop) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.hold_wr = 1'b1;
          state_nxt   = stat.expected ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.run_end) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // an expected held item always starts a drain
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.hold_wr && stat.expected) |=> state_r == S_READ)
    else $error("expected item held without a drain");

  // every slot read is followed by a cycle that can emit it
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> state_r == S_EMIT)
    else $error("slot read outside a drain");

endmodule

[hdl/receive_reorder_buffer.sv]
// top level of the receive reorder buffer
//
//   channel | ports                      | direction | handshake
//   --------+----------------------------+-----------+----------------
//   input   | in_* event header fields   | in        | in_valid/in_stall
//   result  | out_* delivered event      | out       | out_valid/out_stall
//
// an item is captured, then decided; that step gives no result, a single
// pass-through result, or holds the item; an item that completes an in-order run
// is held, then after one store read its run gives one result per cycle unless stalled.
// reset clears the slot valid bits, the expected and previous sequences.
// a held result waits in the output register; a stall there holds a drain.
module receive_reorder_buffer #(
  parameter int SEQ_BITS   = 7,
  parameter int DUP_WINDOW = 64,
  parameter int REF_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_first_in_packet,
  input  logic                            in_guaranteed,
  input  logic                            in_continuous,
  input  logic                            in_has_explicit,
  input  logic [rrb_pkg::SEQ_PORT_W-1:0]  in_explicit_seq,
  input  logic [rrb_pkg::TAG_W-1:0]       in_class_tag,
  input  logic [REF_BITS-1:0]             in_payload_ref,
  input  logic [rrb_pkg::LEN_W-1:0]       in_payload_len,
  input  logic                            in_truncated,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rrb_pkg::SEQ_PORT_W-1:0]  out_seq,
  output logic                            out_ordered,
  output logic                            out_guaranteed,
  output logic [rrb_pkg::TAG_W-1:0]       out_class_tag,
  output logic [REF_BITS-1:0]             out_payload_ref,
  output logic [rrb_pkg::LEN_W-1:0]       out_payload_len,
  output logic                            out_last
);

  rrb_pkg::rrb_cmd_t  cmd;
  rrb_pkg::rrb_stat_t stat;

  // control
  rrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  rrb_datapath #(
    .SEQ_BITS   (SEQ_BITS),
    .DUP_WINDOW (DUP_WINDOW),
    .REF_BITS   (REF_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_first_in_packet (in_first_in_packet),
    .in_guaranteed      (in_guaranteed),
    .in_continuous      (in_continuous),
    .in_has_explicit    (in_has_explicit),
    .in_explicit_seq    (in_explicit_seq),
    .in_class_tag       (in_class_tag),
    .in_payload_ref     (in_payload_ref),
    .in_payload_len     (in_payload_len),
    .in_truncated       (in_truncated),
    .cmd                (cmd),
    .stat               (stat),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_seq            (out_seq),
    .out_ordered        (out_ordered),
    .out_guaranteed     (out_guaranteed),
    .out_class_tag      (out_class_tag),
    .out_payload_ref    (out_payload_ref),
    .out_payload_len    (out_payload_len),
    .out_last           (out_last)
  );

endmodule
